### design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// antecedent in this cycle implies consequent in the next one
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/rve_pkg.sv
// types and constants of the rail voltage code encoder
package rve_pkg;

  // input item
  typedef struct packed {
    logic [1:0]  rail_kind;
    logic [15:0] millivolts;
    logic [7:0]  prior_register;
  } req_t;

  // result item
  typedef struct packed {
    logic        status;
    logic [7:0]  code_value;
    logic [7:0]  register_value;
    logic [11:0] programmed_mv;
  } res_t;

  // rail kinds
  localparam logic [1:0] RailBuck   = 2'd0;
  localparam logic [1:0] RailLdo123 = 2'd1;
  localparam logic [1:0] RailLdo4   = 2'd2;

  // accepted request window
  localparam logic [15:0] MvMin = 16'd500;
  localparam logic [15:0] MvMax = 16'd3300;

  // status codes
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusReject = 1'b1;

  // scale segments
  typedef enum logic [2:0] {
    SEG_BUCK0,
    SEG_BUCK1,
    SEG_BUCK2,
    SEG_BUCK3,
    SEG_LDO123,
    SEG_LDO4
  } seg_e;

  // division by a step is a multiply by a rounded-up reciprocal, exact for 12-bit values
  localparam int unsigned XW        = 12;
  localparam int unsigned RecipW    = 16;
  localparam int unsigned DivShift  = 18;
  localparam logic [RecipW-1:0] Recip5  = RecipW'((2**DivShift + 4) / 5);
  localparam logic [RecipW-1:0] Recip10 = RecipW'((2**DivShift + 9) / 10);
  localparam logic [RecipW-1:0] Recip20 = RecipW'((2**DivShift + 19) / 20);
  localparam logic [RecipW-1:0] Recip25 = RecipW'((2**DivShift + 24) / 25);
  localparam logic [RecipW-1:0] Recip50 = RecipW'((2**DivShift + 49) / 50);

  // LDO scale floors
  localparam logic [15:0] Ldo123Floor = 16'd600;
  localparam logic [15:0] Ldo4Floor   = 16'd1200;

  // register byte fields
  localparam logic [7:0] KeepMask = 8'h80;
  localparam logic [7:0] Vset6Mask = 8'h3F;
  localparam logic [7:0] Vset7Mask = 8'h7F;

  // segment set-up from selector to scaler
  typedef struct packed {
    seg_e            seg;
    logic [XW-1:0]   x;
    logic [RecipW-1:0] recip;
    logic [7:0]      base_code;
    logic [7:0]      span;
    logic [11:0]     base_mv;
  } seg_ctrl_t;

  // scaler result
  typedef struct packed {
    logic [7:0]  code;
    logic [11:0] programmed_mv;
  } scale_t;

endpackage

### design/rve_seg_sel.sv
// segment selection and rounding offset for one request
module rve_seg_sel (
  input  rve_pkg::req_t     req_i,
  output rve_pkg::seg_ctrl_t ctrl_o
);

  logic [15:0] mv;
  logic [11:0] mv12;

  assign mv   = req_i.millivolts;
  assign mv12 = mv[11:0];

  // pick the scale segment; x carries the rounding half step
  always_comb begin
    ctrl_o = '0;
    unique case (req_i.rail_kind)
      rve_pkg::RailBuck: begin
        priority if (mv <= 16'd600) begin
          ctrl_o.seg       = rve_pkg::SEG_BUCK0;
          ctrl_o.x         = mv12 - 12'd290;
          ctrl_o.recip     = rve_pkg::Recip20;
          ctrl_o.base_code = 8'h00;
          ctrl_o.span      = 8'h0F;
          ctrl_o.base_mv   = 12'd300;
        end else if (mv <= 16'd1100) begin
          ctrl_o.seg       = rve_pkg::SEG_BUCK1;
          ctrl_o.x         = mv12 - 12'd598;
          ctrl_o.recip     = rve_pkg::Recip5;
          ctrl_o.base_code = 8'h0F;
          ctrl_o.span      = 8'h73 - 8'h0F;
          ctrl_o.base_mv   = 12'd600;
        end else if (mv <= 16'd1660) begin
          ctrl_o.seg       = rve_pkg::SEG_BUCK2;
          ctrl_o.x         = mv12 - 12'd1095;
          ctrl_o.recip     = rve_pkg::Recip10;
          ctrl_o.base_code = 8'h73;
          ctrl_o.span      = 8'hAB - 8'h73;
          ctrl_o.base_mv   = 12'd1100;
        end else begin
          ctrl_o.seg       = rve_pkg::SEG_BUCK3;
          ctrl_o.x         = mv12 - 12'd1650;
          ctrl_o.recip     = rve_pkg::Recip20;
          ctrl_o.base_code = 8'hAB;
          ctrl_o.span      = 8'hFF - 8'hAB;
          ctrl_o.base_mv   = 12'd1660;
        end
      end
      rve_pkg::RailLdo123: begin
        ctrl_o.seg       = rve_pkg::SEG_LDO123;
        ctrl_o.x         = ((mv < rve_pkg::Ldo123Floor) ? rve_pkg::Ldo123Floor[11:0] : mv12)
                           - 12'd575;
        ctrl_o.recip     = rve_pkg::Recip50;
        ctrl_o.base_code = 8'h04;
        ctrl_o.span      = 8'h3A - 8'h04;
        ctrl_o.base_mv   = 12'd600;
      end
      default: begin
        ctrl_o.seg       = rve_pkg::SEG_LDO4;
        ctrl_o.x         = ((mv < rve_pkg::Ldo4Floor) ? rve_pkg::Ldo4Floor[11:0] : mv12)
                           - 12'd1188;
        ctrl_o.recip     = rve_pkg::Recip25;
        ctrl_o.base_code = 8'h20;
        ctrl_o.span      = 8'h74 - 8'h20;
        ctrl_o.base_mv   = 12'd1200;
      end
    endcase
  end

endmodule

### design/rve_scale.sv
// constant division, saturation and applied voltage for one segment
module rve_scale (
  input  rve_pkg::seg_ctrl_t ctrl_i,
  output rve_pkg::scale_t    scale_o
);

  localparam int unsigned ProdW = rve_pkg::XW + rve_pkg::RecipW;
  localparam int unsigned QW    = ProdW - rve_pkg::DivShift;

  logic [ProdW-1:0] prod;
  logic [QW-1:0]    quot;
  logic [7:0]       steps;
  logic [11:0]      step_mv;

  // quotient by reciprocal multiply
  assign prod = ProdW'(ctrl_i.x) * ProdW'(ctrl_i.recip);
  assign quot = prod[ProdW-1:rve_pkg::DivShift];

  // saturate at the segment's top code
  assign steps = (quot > QW'(ctrl_i.span)) ? ctrl_i.span : quot[7:0];

  // steps times the segment's step size, shift-add constants
  always_comb begin
    unique case (ctrl_i.seg)
      rve_pkg::SEG_BUCK0,
      rve_pkg::SEG_BUCK3:  step_mv = 12'(steps) * 12'd20;
      rve_pkg::SEG_BUCK1:  step_mv = 12'(steps) * 12'd5;
      rve_pkg::SEG_BUCK2:  step_mv = 12'(steps) * 12'd10;
      rve_pkg::SEG_LDO123: step_mv = 12'(steps) * 12'd50;
      default:             step_mv = 12'(steps) * 12'd25;
    endcase
  end

  assign scale_o.code          = ctrl_i.base_code + steps;
  assign scale_o.programmed_mv = ctrl_i.base_mv + step_mv;

endmodule

### design/rail_voltage_code_encoder.sv
// top level of the rail voltage code encoder
// An item is taken at every clock edge where start is high; busy stays low,
// so a new request may follow in every cycle. Each result passes through the
// request register and then the result register, with the segment select,
// reciprocal multiply and saturation between them, and appears on result_o
// marked by done_o, which is high for exactly one cycle.
// The receiver cannot stall, so it must take every strobe.
`include "assert_macros.svh"

module rail_voltage_code_encoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rve_pkg::req_t  req_i,
  output logic           done_o,
  output rve_pkg::res_t  result_o
);

  logic               vld_q;
  rve_pkg::req_t      req_q;
  logic               done_q;
  rve_pkg::res_t      res_q;
  rve_pkg::res_t      res_d;
  rve_pkg::seg_ctrl_t ctrl;
  rve_pkg::scale_t    scale;
  logic               reject;

  assign busy = 1'b0;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  rve_seg_sel u_seg_sel (
    .req_i  (req_q),
    .ctrl_o (ctrl)
  );

  rve_scale u_scale (
    .ctrl_i  (ctrl),
    .scale_o (scale)
  );

  // range check and register byte assembly
  assign reject = (req_q.millivolts < rve_pkg::MvMin) ||
                  (req_q.millivolts > rve_pkg::MvMax) ||
                  ((req_q.rail_kind != rve_pkg::RailBuck) &&
                   (req_q.rail_kind != rve_pkg::RailLdo123) &&
                   (req_q.rail_kind != rve_pkg::RailLdo4));

  always_comb begin
    res_d            = '0;
    res_d.status     = rve_pkg::StatusReject;
    if (!reject) begin
      res_d.status        = rve_pkg::StatusOk;
      res_d.code_value    = scale.code;
      res_d.programmed_mv = scale.programmed_mv;
      unique case (req_q.rail_kind)
        rve_pkg::RailBuck:   res_d.register_value = scale.code;
        rve_pkg::RailLdo123: res_d.register_value =
            (req_q.prior_register & rve_pkg::KeepMask) |
            {scale.code[6:0] & rve_pkg::Vset6Mask[6:0], 1'b0};
        default:             res_d.register_value =
            (req_q.prior_register & rve_pkg::KeepMask) |
            (scale.code & rve_pkg::Vset7Mask);
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  `ASSERT_NEXT(a_accept_to_stage, start && !busy, vld_q)
  `ASSERT_NEXT(a_stage_to_done, vld_q, done_o)
  `ASSERT_CLK(a_reject_zero,
      (done_o && result_o.status == rve_pkg::StatusReject) |->
      (result_o.code_value == 8'h00 && result_o.register_value == 8'h00 &&
       result_o.programmed_mv == 12'd0))
  `ASSERT_CLK(a_applied_range,
      (done_o && result_o.status == rve_pkg::StatusOk) |->
      (result_o.programmed_mv >= 12'd300 && result_o.programmed_mv <= 12'd3340))

endmodule

### dv/rail_voltage_code_encoder_checker.sv
// checker of the rail voltage code encoder: predicts each result and compares it
module rail_voltage_code_encoder_checker
  import rve_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  res_t        result_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  // results still owed by the block, oldest first
  res_t expected_codes[$];

  // voltage request to code, register byte and programmed millivolts
  function automatic res_t encode_request(req_t r);
    res_t        res;
    int unsigned mv;
    int unsigned code;
    int unsigned mv_out;
    res    = '0;
    mv     = r.millivolts;
    code   = 0;
    mv_out = 0;
    // outside the supported window nothing is programmed
    if (mv < MvMin || mv > MvMax) begin
      res.status = StatusReject;
      return res;
    end
    res.status = StatusOk;
    case (r.rail_kind)
      RailBuck: begin
        // four segments, each rounded to nearest and capped at its top code
        if (mv <= 600) begin
          code = (mv - 290) / 20;
          if (code > 'h0F) code = 'h0F;
          mv_out = 300 + code * 20;
        end else if (mv <= 1100) begin
          code = 'h0F + (mv - 598) / 5;
          if (code > 'h73) code = 'h73;
          mv_out = 600 + (code - 'h0F) * 5;
        end else if (mv <= 1660) begin
          code = 'h73 + (mv - 1095) / 10;
          if (code > 'hAB) code = 'hAB;
          mv_out = 1100 + (code - 'h73) * 10;
        end else begin
          code = 'hAB + (mv - 1650) / 20;
          if (code > 'hFF) code = 'hFF;
          mv_out = 1660 + (code - 'hAB) * 20;
        end
        res.register_value = 8'(code);
      end
      RailLdo123: begin
        // 50 mV steps from the floor, field in bits 6:1, bit 0 cleared
        if (mv < Ldo123Floor) mv = Ldo123Floor;
        code = 'h04 + (mv - 575) / 50;
        if (code > 'h3A) code = 'h3A;
        mv_out = 600 + (code - 'h04) * 50;
        res.register_value = {r.prior_register[7], 6'(code), 1'b0};
      end
      RailLdo4: begin
        // 25 mV steps from the floor, field in bits 6:0
        if (mv < Ldo4Floor) mv = Ldo4Floor;
        code = 'h20 + (mv - 1188) / 25;
        if (code > 'h74) code = 'h74;
        mv_out = 1200 + (code - 'h20) * 25;
        res.register_value = {r.prior_register[7], 7'(code)};
      end
      default: begin
        // unused rail kind is turned away like a bad voltage
        res.status = StatusReject;
        return res;
      end
    endcase
    res.code_value    = 8'(code);
    res.programmed_mv = 12'(mv_out);
    return res;
  endfunction

  // compare strobed results first, then record the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned errs;
    res_t        want;
    if (!rst_ni) begin
      expected_codes.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      errs = 0;
      if (done_i) begin
        if (expected_codes.size() == 0) begin
          $error("result strobed with no request outstanding");
          errs++;
        end else begin
          want = expected_codes.pop_front();
          if (result_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_i.status);
            errs++;
          end
          if (result_i.code_value !== want.code_value) begin
            $error("code_value: expected 0x%02h, got 0x%02h",
                   want.code_value, result_i.code_value);
            errs++;
          end
          if (result_i.register_value !== want.register_value) begin
            $error("register_value: expected 0x%02h, got 0x%02h",
                   want.register_value, result_i.register_value);
            errs++;
          end
          if (result_i.programmed_mv !== want.programmed_mv) begin
            $error("programmed_mv: expected %0d, got %0d",
                   want.programmed_mv, result_i.programmed_mv);
            errs++;
          end
        end
      end
      if (start_i && !busy_i) expected_codes.push_back(encode_request(req_i));
      mismatch_count_o <= mismatch_count_o + errs;
      pending_o        <= expected_codes.size();
    end
  end

endmodule

### dv/rail_voltage_code_encoder_test.sv
// testbench top of the rail voltage code encoder: clock, reset, requests and verdict
module rail_voltage_code_encoder_test;
  import rve_pkg::*;

  // rail kind with no regulator behind it
  localparam logic [1:0] RailUnused = 2'd3;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  res_t        result_o;
  int unsigned mismatch_count;
  int unsigned pending_count;

  // voltages where the scales change or the window ends
  int unsigned edge_points[9] = '{500, 600, 1100, 1200, 1660, 2000, 3300, 625, 1213};

  always #2 clk_i = ~clk_i;

  rail_voltage_code_encoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  rail_voltage_code_encoder_checker code_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .done_i           (done_o),
    .result_i         (result_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  function automatic req_t make_req(logic [1:0] kind, logic [15:0] mv, logic [7:0] prior);
    req_t r;
    r.rail_kind      = kind;
    r.millivolts     = mv;
    r.prior_register = prior;
    return r;
  endfunction

  // mostly valid requests, some near scale edges, the rest anything at all
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick             = $urandom_range(0, 99);
    r.prior_register = 8'($urandom);
    if (pick < 70) begin
      r.rail_kind  = 2'($urandom_range(0, 2));
      r.millivolts = 16'($urandom_range(500, 3300));
    end else if (pick < 85) begin
      r.rail_kind  = 2'($urandom_range(0, 2));
      r.millivolts = 16'(edge_points[$urandom_range(0, 8)] + $urandom_range(0, 6) - 3);
    end else begin
      r.rail_kind  = 2'($urandom);
      r.millivolts = 16'($urandom);
    end
    return r;
  endfunction

  // offer one item after random idle cycles and wait until it is taken
  task automatic send_request(req_t r, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t        directed[$];
    int unsigned idle_plan[4];
    start     <= 1'b0;
    req_i     <= '0;
    idle_plan = '{0, 82, 35, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window limits, every buck segment edge, LDO floors and tops, unused kind
    directed = '{
      make_req(RailBuck,   16'd0,     8'h00),
      make_req(RailBuck,   16'd499,   8'hFF),
      make_req(RailBuck,   16'd500,   8'h00),
      make_req(RailBuck,   16'd600,   8'hFF),
      make_req(RailBuck,   16'd601,   8'h00),
      make_req(RailBuck,   16'd1100,  8'h00),
      make_req(RailBuck,   16'd1101,  8'hFF),
      make_req(RailBuck,   16'd1660,  8'h00),
      make_req(RailBuck,   16'd1661,  8'h00),
      make_req(RailBuck,   16'd3300,  8'hFF),
      make_req(RailBuck,   16'd3301,  8'h00),
      make_req(RailBuck,   16'hFFFF,  8'hFF),
      make_req(RailLdo123, 16'd500,   8'hFF),
      make_req(RailLdo123, 16'd600,   8'h00),
      make_req(RailLdo123, 16'd624,   8'h80),
      make_req(RailLdo123, 16'd625,   8'h7F),
      make_req(RailLdo123, 16'd3300,  8'h80),
      make_req(RailLdo4,   16'd500,   8'hFF),
      make_req(RailLdo4,   16'd1199,  8'h00),
      make_req(RailLdo4,   16'd1212,  8'h80),
      make_req(RailLdo4,   16'd1213,  8'h7F),
      make_req(RailLdo4,   16'd3300,  8'hFF),
      make_req(RailUnused, 16'd1000,  8'hFF)
    };
    foreach (directed[i]) send_request(directed[i], 0);
    drain();

    // random items under each idling pattern, fully drained between phases
    foreach (idle_plan[p]) begin
      repeat (350) send_request(random_req(), idle_plan[p]);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rail_voltage_code_encoder regression: pass");
    end else begin
      $display("rail_voltage_code_encoder regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("rail_voltage_code_encoder regression: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/rve_pkg.sv
design/rve_seg_sel.sv
design/rve_scale.sv
design/rail_voltage_code_encoder.sv
dv/rail_voltage_code_encoder_checker.sv
dv/rail_voltage_code_encoder_test.sv
